// ===== hdl/bfa_pkg.sv =====
// Package for the best-fit block allocator: field structs, status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package bfa_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned AddrBitsDef     = 16;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoFit   = 2'd1,
    StUnknown = 2'd2,
    StFull    = 2'd3
  } status_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic [16:0] req_words;
    logic [15:0] release_base;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_base;
    logic [16:0] result_words;
  } rsp_t;

  typedef enum logic [2:0] {
    SIdle,
    SAllocScan,
    SAllocDone,
    SFindUsed,
    SMergeScan,
    SFreeDone,
    SOut
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic   load;        // capture request, clear scan state
    logic   scan_step;   // examine current entry, advance index
    logic   rescan;      // restart merge scan from entry 0
    logic   alloc_commit;
    logic   free_commit;
    logic   err_nofit;
    logic   err_unknown;
    logic   err_full;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;          // current index is the last entry
    logic hit_now;       // current entry matches (search or merge)
    logic best_ok;       // a fitting free block was found
    logic uslot_ok;      // an empty used slot exists
    logic fslot_ok;      // merge slot or empty free slot exists
    logic zero_req;
  } sts_t;

endpackage

// ===== hdl/bfa_ctrl.sv =====
// Controller state machine for the best-fit allocator.
// Depends on bfa_pkg.
module bfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           opcode_i,
  input  bfa_pkg::sts_t  sts_i,
  output bfa_pkg::cmd_t  cmd_o
);

  bfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      bfa_pkg::SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (opcode_i == bfa_pkg::OpFree) ? bfa_pkg::SFindUsed
                                                   : bfa_pkg::SAllocScan;
        end
      end
      bfa_pkg::SAllocScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last) state_d = bfa_pkg::SAllocDone;
      end
      bfa_pkg::SAllocDone: begin
        priority if (sts_i.zero_req || !sts_i.best_ok) cmd_o.err_nofit = 1'b1;
        else if (!sts_i.uslot_ok) cmd_o.err_full = 1'b1;
        else cmd_o.alloc_commit = 1'b1;
        state_d = bfa_pkg::SOut;
      end
      bfa_pkg::SFindUsed: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit_now) begin
          cmd_o.rescan = 1'b1;
          state_d = bfa_pkg::SMergeScan;
        end else if (sts_i.last) begin
          cmd_o.err_unknown = 1'b1;
          state_d = bfa_pkg::SOut;
        end
      end
      bfa_pkg::SMergeScan: begin
        // A merge restarts the scan at entry 0, as each absorbed block may expose new neighbors.
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit_now) begin
          cmd_o.rescan = 1'b1;
        end else if (sts_i.last) begin
          state_d = bfa_pkg::SFreeDone;
        end
      end
      bfa_pkg::SFreeDone: begin
        if (sts_i.fslot_ok) cmd_o.free_commit = 1'b1;
        else cmd_o.err_full = 1'b1;
        state_d = bfa_pkg::SOut;
      end
      bfa_pkg::SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = bfa_pkg::SIdle;
      end
      default: state_d = bfa_pkg::SIdle;
    endcase
  end

endmodule

// ===== hdl/bfa_dp.sv =====
// Datapath for the best-fit allocator: free and used tables, scan index,
// best-fit tracker, merge accumulator and result register. Depends on bfa_pkg.
module bfa_dp #(
  parameter int unsigned TableEntries = bfa_pkg::TableEntriesDef,
  parameter int unsigned AddrBits     = bfa_pkg::AddrBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_wdata_i,
  input  bfa_pkg::req_t req_i,
  input  bfa_pkg::cmd_t cmd_i,
  output bfa_pkg::sts_t sts_o,
  output bfa_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned LenW = AddrBits + 1;
  localparam logic [LenW-1:0] PoolMax = {1'b1, {AddrBits{1'b0}}};
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  logic [AddrBits-1:0] fs_q [TableEntries];
  logic [LenW-1:0]     fl_q [TableEntries];
  logic [TableEntries-1:0] fv_q;
  logic [AddrBits-1:0] us_q [TableEntries];
  logic [LenW-1:0]     ul_q [TableEntries];
  logic [TableEntries-1:0] uv_q;

  logic [IdxW-1:0]     idx_q;
  logic [LenW-1:0]     req_q;
  logic [AddrBits-1:0] rbase_q;
  logic                best_ok_q;
  logic [IdxW-1:0]     best_q;
  logic [LenW-1:0]     slack_q;
  logic [IdxW-1:0]     uidx_q;
  logic [AddrBits-1:0] cs_q;
  logic [LenW:0]       cl_q;
  logic [LenW-1:0]     rel_q;
  logic                slot_ok_q;
  logic [IdxW-1:0]     slot_q;
  logic                merged_q;
  bfa_pkg::rsp_t       rsp_q;

  logic [LenW-1:0] pool_sat;
  logic [LenW-1:0] cur_len, slack_now;
  logic [AddrBits-1:0] cur_start;
  logic fit_now, better, used_hit, ends_at, starts_at, merge_hit;
  logic [LenW:0] end_cur, end_free;
  logic uempty_ok, fempty_ok;
  logic [IdxW-1:0] uempty, fempty;

  assign pool_sat  = (cfg_wdata_i > PoolMax) ? PoolMax : LenW'(cfg_wdata_i);
  assign cur_len   = fl_q[idx_q];
  assign cur_start = fs_q[idx_q];
  assign fit_now   = fv_q[idx_q] && (cur_len >= req_q);
  assign slack_now = cur_len - req_q;
  assign better    = !best_ok_q || (slack_now < slack_q) ||
                     ((slack_now == slack_q) && (cur_start < fs_q[best_q]));
  assign used_hit  = uv_q[idx_q] && (us_q[idx_q] == rbase_q);
  assign end_cur   = (LenW+1)'(cs_q) + cl_q;
  assign end_free  = (LenW+1)'(cur_start) + (LenW+1)'(cur_len);
  assign ends_at   = ((LenW+1)'(cur_start) == end_cur);
  assign starts_at = (end_free == (LenW+1)'(cs_q));
  assign merge_hit = fv_q[idx_q] && (ends_at || starts_at);

  // Lowest empty slot in each table; a priority encoder over valid bits.
  always_comb begin
    uempty_ok = 1'b0;
    fempty_ok = 1'b0;
    uempty    = '0;
    fempty    = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!uv_q[i]) begin
        uempty_ok = 1'b1;
        uempty    = IdxW'(i);
      end
      if (!fv_q[i]) begin
        fempty_ok = 1'b1;
        fempty    = IdxW'(i);
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.last     = (idx_q == LastIdx);
    sts_o.hit_now  = merged_q ? merge_hit : used_hit;
    sts_o.best_ok  = best_ok_q;
    sts_o.uslot_ok = uempty_ok;
    sts_o.fslot_ok = slot_ok_q || fempty_ok;
    sts_o.zero_req = (req_q == '0);
  end

  // merged_q doubles as "merge phase active" so hit_now selects the right test.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q     <= TableEntries'(1);
      uv_q     <= '0;
      idx_q    <= '0;
      merged_q <= 1'b0;
      best_ok_q <= 1'b0;
      slot_ok_q <= 1'b0;
    end else if (cfg_we_i) begin
      uv_q   <= '0;
      fv_q   <= TableEntries'(pool_sat != '0);
    end else begin
      if (cmd_i.load) begin
        idx_q     <= '0;
        best_ok_q <= 1'b0;
        slot_ok_q <= 1'b0;
        merged_q  <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= cmd_i.rescan ? '0 : idx_q + IdxW'(1);
        if (!merged_q && req_q[LenW-1:0] != '0 && fit_now && better && !rsp_q.status[1]) begin
          best_ok_q <= 1'b1;
        end
        if (cmd_i.rescan) begin
          merged_q <= 1'b1;
          if (merged_q) begin
            fv_q[idx_q] <= 1'b0;
            if (!slot_ok_q) slot_ok_q <= 1'b1;
          end
        end
      end
      if (cmd_i.alloc_commit) begin
        uv_q[uempty] <= 1'b1;
        if (slack_q == '0) fv_q[best_q] <= 1'b0;
      end
      if (cmd_i.free_commit) begin
        fv_q[slot_ok_q ? slot_q : fempty] <= 1'b1;
        uv_q[uidx_q] <= 1'b0;
      end
      if (cmd_i.err_full || cmd_i.err_nofit || cmd_i.err_unknown) merged_q <= 1'b0;
      if (cmd_i.alloc_commit || cmd_i.free_commit) merged_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) begin
        fs_q[i] <= '0;
        fl_q[i] <= (i == 0) ? PoolMax : '0;
        us_q[i] <= '0;
        ul_q[i] <= '0;
      end
      req_q   <= '0;
      rbase_q <= '0;
      best_q  <= '0;
      slack_q <= '0;
      uidx_q  <= '0;
      cs_q    <= '0;
      cl_q    <= '0;
      rel_q   <= '0;
      slot_q  <= '0;
      rsp_q   <= '0;
    end else if (cfg_we_i) begin
      fs_q[0] <= '0;
      fl_q[0] <= pool_sat;
    end else begin
      if (cmd_i.load) begin
        req_q   <= LenW'(req_i.req_words);
        rbase_q <= AddrBits'(req_i.release_base);
        rsp_q   <= '0;
      end
      if (cmd_i.scan_step) begin
        if (!merged_q && fit_now && better) begin
          best_q  <= idx_q;
          slack_q <= slack_now;
        end
        if (cmd_i.rescan) begin
          if (!merged_q) begin
            uidx_q <= idx_q;
            cs_q   <= us_q[idx_q];
            cl_q   <= (LenW+1)'(ul_q[idx_q]);
            rel_q  <= ul_q[idx_q];
          end else begin
            if (!slot_ok_q) slot_q <= idx_q;
            cl_q <= cl_q + (LenW+1)'(cur_len);
            if (!ends_at) cs_q <= cur_start;
          end
        end
      end
      if (cmd_i.alloc_commit) begin
        us_q[uempty] <= fs_q[best_q];
        ul_q[uempty] <= req_q;
        if (slack_q != '0) begin
          fs_q[best_q] <= fs_q[best_q] + req_q[AddrBits-1:0];
          fl_q[best_q] <= slack_q;
        end
        rsp_q.status       <= bfa_pkg::StOk;
        rsp_q.result_base  <= 16'(fs_q[best_q]);
        rsp_q.result_words <= 17'(req_q);
      end
      if (cmd_i.free_commit) begin
        fs_q[slot_ok_q ? slot_q : fempty] <= cs_q;
        fl_q[slot_ok_q ? slot_q : fempty] <= cl_q[LenW-1:0];
        rsp_q.status       <= bfa_pkg::StOk;
        rsp_q.result_base  <= 16'(rbase_q);
        rsp_q.result_words <= 17'(rel_q);
      end
      if (cmd_i.err_nofit)   rsp_q.status <= bfa_pkg::StNoFit;
      if (cmd_i.err_unknown) rsp_q.status <= bfa_pkg::StUnknown;
      if (cmd_i.err_full)    rsp_q.status <= bfa_pkg::StFull;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== hdl/best_fit_block_allocator_top.sv =====
// Best-fit block allocator with coalescing free, one word in flight at a time. The table
// scan, one entry per cycle, sets the timing: an allocate scans the whole free table once;
// a free scans the used table for the block, rescans the free table from entry 0 after each
// absorbed neighbor (at most two) and then makes a final pass. The next request is accepted
// in the cycle after the result is taken. Reset (async, active low) gives one free block of
// 65536 words and no used blocks, as a cfg_we_i write of 65536 does.
module best_fit_block_allocator_top #(
  parameter int unsigned TableEntries = bfa_pkg::TableEntriesDef,
  parameter int unsigned AddrBits     = bfa_pkg::AddrBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bfa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bfa_pkg::rsp_t out_data_o
);

  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .opcode_i    (in_data_i.opcode),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfa_dp #(
    .TableEntries (TableEntries),
    .AddrBits     (AddrBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (out_data_o)
  );

endmodule

// ===== verif/tb_best_fit_block_allocator_top.sv =====
// Self-checking testbench for best_fit_block_allocator_top: directed and random
// allocate/free traffic checked against an in-bench table predictor.
// Depends on hdl/bfa_pkg.sv and hdl/best_fit_block_allocator_top.sv.
`timescale 1ns / 100ps

module tb_best_fit_block_allocator_top;

  localparam int Entries   = 16;
  localparam int PoolMax   = 65536;
  localparam int IdleLimit = 20000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [16:0]   cfg_wdata_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  bfa_pkg::req_t in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  bfa_pkg::rsp_t out_data_o;

  best_fit_block_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Predicted allocator state.
  int          pool_size;
  logic [15:0] fr_start [Entries];
  logic [16:0] fr_len   [Entries];
  logic        fr_vld   [Entries];
  logic [15:0] us_start [Entries];
  logic [16:0] us_len   [Entries];
  logic        us_vld   [Entries];

  bfa_pkg::rsp_t pending_rsp[$];
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   errors = 0;
  int   words_sent = 0;
  int   words_checked = 0;
  int   idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_tables(int words);
    pool_size = (words > PoolMax) ? PoolMax : words;
    for (int i = 0; i < Entries; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_vld[i] = 1'b0;
      us_start[i] = '0; us_len[i] = '0; us_vld[i] = 1'b0;
    end
    if (pool_size != 0) begin
      fr_len[0] = 17'(pool_size);
      fr_vld[0] = 1'b1;
    end
  endfunction

  function automatic bfa_pkg::rsp_t make_rsp(bfa_pkg::status_e st, int base, int words);
    bfa_pkg::rsp_t r;
    r.status       = st;
    r.result_base  = 16'(base);
    r.result_words = 17'(words);
    return r;
  endfunction

  function automatic bfa_pkg::rsp_t predict_alloc(int req);
    int best = -1;
    int best_slack = 0;
    int uslot = -1;
    int slack;
    int base;
    if (req == 0) return make_rsp(bfa_pkg::StNoFit, 0, 0);
    for (int i = 0; i < Entries; i++) begin
      if (fr_vld[i] && int'(fr_len[i]) >= req) begin
        slack = int'(fr_len[i]) - req;
        if (best < 0 || slack < best_slack ||
            (slack == best_slack && fr_start[i] < fr_start[best])) begin
          best = i;
          best_slack = slack;
        end
      end
    end
    if (best < 0) return make_rsp(bfa_pkg::StNoFit, 0, 0);
    for (int i = Entries - 1; i >= 0; i--) if (!us_vld[i]) uslot = i;
    if (uslot < 0) return make_rsp(bfa_pkg::StFull, 0, 0);
    base = int'(fr_start[best]);
    us_start[uslot] = 16'(base);
    us_len[uslot]   = 17'(req);
    us_vld[uslot]   = 1'b1;
    if (best_slack == 0) begin
      fr_vld[best] = 1'b0;
    end else begin
      fr_start[best] = 16'(base + req);
      fr_len[best]   = 17'(best_slack);
    end
    return make_rsp(bfa_pkg::StOk, base, req);
  endfunction

  function automatic bfa_pkg::rsp_t predict_free(logic [15:0] rbase);
    int  u = -1;
    int  slot = -1;
    int  cur_s, cur_l, released;
    bit  merged;
    for (int i = Entries - 1; i >= 0; i--) if (us_vld[i] && us_start[i] == rbase) u = i;
    if (u < 0) return make_rsp(bfa_pkg::StUnknown, 0, 0);
    cur_s = int'(us_start[u]);
    cur_l = int'(us_len[u]);
    released = cur_l;
    // Absorb touching free blocks one at a time, rescanning after each.
    do begin
      merged = 1'b0;
      for (int i = 0; i < Entries && !merged; i++) begin
        if (!fr_vld[i]) continue;
        if (int'(fr_start[i]) == cur_s + cur_l) begin
          cur_l += int'(fr_len[i]);
          merged = 1'b1;
        end else if (int'(fr_start[i]) + int'(fr_len[i]) == cur_s) begin
          cur_s = int'(fr_start[i]);
          cur_l += int'(fr_len[i]);
          merged = 1'b1;
        end
        if (merged) begin
          fr_vld[i] = 1'b0;
          if (slot < 0) slot = i;
        end
      end
    end while (merged);
    if (slot < 0) begin
      for (int i = Entries - 1; i >= 0; i--) if (!fr_vld[i]) slot = i;
      if (slot < 0) return make_rsp(bfa_pkg::StFull, 0, 0);
    end
    fr_start[slot] = 16'(cur_s);
    fr_len[slot]   = 17'(cur_l);
    fr_vld[slot]   = 1'b1;
    us_vld[u]      = 1'b0;
    return make_rsp(bfa_pkg::StOk, int'(rbase), released);
  endfunction

  task automatic send_word(bfa_pkg::opcode_e op, int req, int rbase);
    bfa_pkg::req_t r;
    r.opcode       = op;
    r.req_words    = 17'(req);
    r.release_base = 16'(rbase);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp.push_back(op == bfa_pkg::OpAlloc ? predict_alloc(req)
                                                 : predict_free(16'(rbase)));
    words_sent++;
  endtask

  task automatic drain;
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_pool(int words);
    drain();
    cfg_wdata_i <= 17'(words);
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reset_tables(words);
  endtask

  function automatic int pick_used_base();
    int idx[$];
    for (int i = 0; i < Entries; i++) if (us_vld[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return int'(us_start[idx[$urandom_range(idx.size() - 1)]]);
  endfunction

  task automatic test_directed;
    send_word(bfa_pkg::OpAlloc, 0, 0);
    send_word(bfa_pkg::OpAlloc, PoolMax, 0);
    send_word(bfa_pkg::OpAlloc, 1, 0);
    send_word(bfa_pkg::OpFree, 0, 16'hFFFF);
    send_word(bfa_pkg::OpFree, 0, 5);
    for (int i = 0; i < Entries; i++) send_word(bfa_pkg::OpAlloc, 3, 0);
    send_word(bfa_pkg::OpAlloc, 1, 0);
    send_word(bfa_pkg::OpFree, 0, 3);
    send_word(bfa_pkg::OpFree, 0, 6);
    write_pool(1);
    send_word(bfa_pkg::OpAlloc, 2, 0);
    send_word(bfa_pkg::OpAlloc, 1, 0);
    write_pool(0);
    send_word(bfa_pkg::OpAlloc, 1, 0);
    // Values above the address range saturate to the full pool.
    write_pool(17'h1FFFF);
    send_word(bfa_pkg::OpAlloc, PoolMax, 0);
  endtask

  task automatic test_random(int pool, int count);
    int sel, base;
    write_pool(pool);
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(99);
      base = pick_used_base();
      if (sel < 45 && base >= 0) begin
        send_word(bfa_pkg::OpFree, $urandom_range(17'h1FFFF), base);
      end else if (sel < 52) begin
        send_word(bfa_pkg::OpFree, $urandom_range(17'h1FFFF), $urandom_range(16'hFFFF));
      end else if (sel < 57) begin
        send_word(bfa_pkg::OpAlloc, $urandom_range(17'h1FFFF), $urandom_range(16'hFFFF));
      end else begin
        send_word(bfa_pkg::OpAlloc, $urandom_range(1, pool / 6 + 2),
                  $urandom_range(16'hFFFF));
      end
    end
  endtask

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    bfa_pkg::rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result word: %p", out_data_o);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_data_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.result_base !== exp_rsp.result_base) begin
          $error("result_base: expected %0d, got %0d",
                 exp_rsp.result_base, out_data_o.result_base);
          errors++;
        end
        if (out_data_o.result_words !== exp_rsp.result_words) begin
          $error("result_words: expected %0d, got %0d",
                 exp_rsp.result_words, out_data_o.result_words);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("best_fit_block_allocator_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    reset_tables(PoolMax);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100, 175);
    snd_idle_pct = 79;
    test_random(PoolMax, 175);
    snd_idle_pct = 0;
    rcv_stall_pct = 79;
    test_random(37, 175);
    snd_idle_pct = 30;
    rcv_stall_pct = 30;
    test_random(1000, 175);
    drain();
    $display("Sent %0d words, checked %0d results over pools 0, 1, 37, 100, 1000, 65536",
             words_sent, words_checked);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("best_fit_block_allocator_top regression: pass");
    end else begin
      $display("best_fit_block_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bfa_pkg.sv
hdl/bfa_ctrl.sv
hdl/bfa_dp.sv
hdl/best_fit_block_allocator_top.sv
verif/tb_best_fit_block_allocator_top.sv
